// ===== rtl/rid_ie_pkg.sv =====
`default_nettype none

package rid_ie_pkg;

   // Frame size limit; the byte counter saturates here
   localparam int FRAME_BYTES  = 4096;
   localparam int OffsetWidth  = 12;
   localparam int PosWidth     = $clog2(FRAME_BYTES + 1);
   // Position just past an element: frame end plus a full element body
   localparam int EndWidth     = $clog2(FRAME_BYTES + 257);
   localparam int CmpWidth     = (EndWidth > OffsetWidth) ? EndWidth : OffsetWidth;

   // Element codes
   localparam logic [7:0] VENDOR_TYPE    = 8'hdd;
   localparam logic [7:0] MIN_VENDOR_LEN = 8'd5;
   localparam logic [7:0] PAYLOAD_SKIP   = 8'd5;

   // Remote ID OUIs
   localparam logic [7:0] OUI_A0 = 8'h90;
   localparam logic [7:0] OUI_A1 = 8'h3a;
   localparam logic [7:0] OUI_A2 = 8'he6;
   localparam logic [7:0] OUI_B0 = 8'hfa;
   localparam logic [7:0] OUI_B1 = 8'h0b;
   localparam logic [7:0] OUI_B2 = 8'hbc;

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_TYPE,
      PH_LEN,
      PH_BODY,
      PH_DONE
   } phase_type;

   // Expected OUI byte at body index 0..2 (index 3 never used)
   function automatic logic [7:0] oui_byte(input logic second, input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = second ? OUI_B0 : OUI_A0;
         2'd1:    val = second ? OUI_B1 : OUI_A1;
         2'd2:    val = second ? OUI_B2 : OUI_A2;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/remote_id_vendor_ie_scanner_top.sv =====
`default_nettype none

// Remote ID vendor element scanner. Frame bytes arrive one per transaction on the
// req_ channel, with req_last_byte marking the final byte. Starting at the byte
// position held in the start offset register, the block walks type-length-value
// elements and latches the first vendor element (type 0xdd, length above 5) that
// carries one of the two Remote ID OUIs. On the last byte it emits one rsp_
// transaction: found, the payload start (element start + 7) and the payload
// length (element length - 5); both are zero when nothing was found, when the
// hit element runs past the frame end, or when the frame exceeds FRAME_BYTES.
// One byte is taken every clock unless req_stall is high: each byte updates the
// parse state registers and the result lands in an output register, so bytes keep
// flowing while a result is presented; req_stall rises only when that output
// register is full and stalled. The result is registered in the cycle after the
// last byte is taken. Write the start offset only between frames.

module remote_id_vendor_ie_scanner_top
   import rid_ie_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   csr_wr_en,
   input  wire logic [OffsetWidth-1:0] csr_wr_data,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_last_byte,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_found,
   output logic [OffsetWidth-1:0]      rsp_payload_start,
   output logic [7:0]                  rsp_payload_length
);

   logic [OffsetWidth-1:0] start_offset_ff;

   logic [PosWidth-1:0]    pos_ff, pos_in;
   phase_type              phase_ff, phase_in, walk_phase;
   logic [7:0]             elem_type_ff, elem_type_in;
   logic [7:0]             elem_len_ff, elem_len_in;
   logic [7:0]             body_rem_ff, body_rem_in;
   logic                   match_a_ff, match_a_in;
   logic                   match_b_ff, match_b_in;
   logic                   hit_valid_ff, hit_valid_in;
   logic [OffsetWidth-1:0] hit_start_ff, hit_start_in;
   logic [7:0]             hit_len_ff, hit_len_in;
   logic [EndWidth-1:0]    hit_end_ff, hit_end_in;

   logic                   rsp_valid_ff;
   logic                   found_ff;
   logic [OffsetWidth-1:0] pay_start_ff, pay_start_in;
   logic [7:0]             pay_len_ff, pay_len_in;

   logic                   req_accept;
   logic                   pos_at_start;
   logic [7:0]             body_idx;
   logic                   found;

   // Input side stalls only when a finished result is held back
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign pos_at_start = (CmpWidth'(pos_ff) == CmpWidth'(start_offset_ff));
   assign body_idx     = elem_len_ff - body_rem_ff;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_offset_ff <= '0;
      end else if (csr_wr_en) begin
         start_offset_ff <= csr_wr_data;
      end
   end

   // Parse state register
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= PH_SKIP;
         elem_type_ff <= '0;
         elem_len_ff  <= '0;
         body_rem_ff  <= '0;
         match_a_ff   <= 1'b1;
         match_b_ff   <= 1'b1;
         hit_valid_ff <= 1'b0;
         hit_start_ff <= '0;
         hit_len_ff   <= '0;
         hit_end_ff   <= '0;
      end else begin
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         elem_type_ff <= elem_type_in;
         elem_len_ff  <= elem_len_in;
         body_rem_ff  <= body_rem_in;
         match_a_ff   <= match_a_in;
         match_b_ff   <= match_b_in;
         hit_valid_ff <= hit_valid_in;
         hit_start_ff <= hit_start_in;
         hit_len_ff   <= hit_len_in;
         hit_end_ff   <= hit_end_in;
      end
   end

   // Element walk: next state for one accepted byte
   always_comb begin
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      elem_type_in = elem_type_ff;
      elem_len_in  = elem_len_ff;
      body_rem_in  = body_rem_ff;
      match_a_in   = match_a_ff;
      match_b_in   = match_b_ff;
      hit_valid_in = hit_valid_ff;
      hit_start_in = hit_start_ff;
      hit_len_in   = hit_len_ff;
      hit_end_in   = hit_end_ff;
      walk_phase   = phase_ff;
      found        = 1'b0;
      pay_start_in = '0;
      pay_len_in   = '0;

      if (req_accept) begin
         if (pos_ff >= PosWidth'(FRAME_BYTES)) begin
            // oversized frame: search ends with no hit
            phase_in     = PH_DONE;
            hit_valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + PosWidth'(1);
            if (phase_ff == PH_SKIP && pos_at_start) begin
               walk_phase = PH_TYPE;
            end
            case (walk_phase)
               PH_TYPE: begin
                  elem_type_in = req_data_byte;
                  phase_in     = PH_LEN;
               end
               PH_LEN: begin
                  elem_len_in = req_data_byte;
                  body_rem_in = req_data_byte;
                  match_a_in  = 1'b1;
                  match_b_in  = 1'b1;
                  phase_in    = (req_data_byte == 8'd0) ? PH_TYPE : PH_BODY;
               end
               PH_BODY: begin
                  if (body_idx < 8'd3) begin
                     match_a_in = match_a_ff && (req_data_byte == oui_byte(1'b0, body_idx[1:0]));
                     match_b_in = match_b_ff && (req_data_byte == oui_byte(1'b1, body_idx[1:0]));
                  end
                  body_rem_in = body_rem_ff - 8'd1;
                  if (body_idx == 8'd2 && elem_type_ff == VENDOR_TYPE &&
                      elem_len_ff > MIN_VENDOR_LEN && (match_a_in || match_b_in)) begin
                     // element starts four bytes back; payload seven bytes in
                     hit_valid_in = 1'b1;
                     hit_start_in = OffsetWidth'(CmpWidth'(pos_ff) + CmpWidth'(3));
                     hit_len_in   = elem_len_ff - PAYLOAD_SKIP;
                     hit_end_in   = EndWidth'(pos_ff) + EndWidth'(elem_len_ff) -
                                    EndWidth'(2);
                     phase_in     = PH_DONE;
                  end else if (body_rem_in == 8'd0) begin
                     phase_in = PH_TYPE;
                  end
               end
               default: begin
               end
            endcase
         end

         // whole element must lie inside the frame
         found = hit_valid_in && (hit_end_in <= EndWidth'(pos_ff) + EndWidth'(1));

         // result fields as they stand before the frame clear
         pay_start_in = found ? hit_start_in : '0;
         pay_len_in   = found ? hit_len_in : '0;

         // frame end: clear for the next frame
         if (req_last_byte) begin
            pos_in       = '0;
            phase_in     = PH_SKIP;
            elem_type_in = '0;
            elem_len_in  = '0;
            body_rem_in  = '0;
            match_a_in   = 1'b1;
            match_b_in   = 1'b1;
            hit_valid_in = 1'b0;
            hit_start_in = '0;
            hit_len_in   = '0;
            hit_end_in   = '0;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && req_last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_last_byte) begin
         found_ff     <= found;
         pay_start_ff <= pay_start_in;
         pay_len_ff   <= pay_len_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_payload_start  = pay_start_ff;
   assign rsp_payload_length = pay_len_ff;

endmodule

`default_nettype wire

// ===== rtl/rid_ie_checker.sv =====
`default_nettype none

module rid_ie_checker
   import rid_ie_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   req_last_byte,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic                   rsp_found,
   input wire logic [OffsetWidth-1:0] rsp_payload_start,
   input wire logic [7:0]             rsp_payload_length
);

   // held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_payload_start) && $stable(rsp_payload_length))
      else $error("result changed while stalled");

   // a miss reports zero payload fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_payload_start == '0 && rsp_payload_length == 8'd0)
      else $error("miss with nonzero payload fields");

   // a hit has a nonempty payload past the element header
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |->
      rsp_payload_length != 8'd0 && rsp_payload_start >= OffsetWidth'(7))
      else $error("hit payload out of range");

   // a last byte transaction yields a result on the next cycle
   a_last_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_byte |=> rsp_valid)
      else $error("last byte without result");

   // no result appears without a last byte
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall && req_last_byte) && !(rsp_valid && rsp_stall)
      |=> !rsp_valid)
      else $error("result without last byte");

endmodule

bind remote_id_vendor_ie_scanner_top rid_ie_checker u_rid_ie_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_last_byte      (req_last_byte),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_found          (rsp_found),
   .rsp_payload_start  (rsp_payload_start),
   .rsp_payload_length (rsp_payload_length)
);

`default_nettype wire
